// ===== rtl/fpu_pkg.sv =====
// shared types, constants and helpers for the fire particle update core
package fpu_pkg;

    // field widths
    localparam int INDEX_W    = 13;
    localparam int WORD_W     = 32;
    localparam int LIFE_W     = 17;
    localparam int FADE_W     = 14;
    localparam int RND_FADE_W = 7;
    localparam int RND_VEL_W  = 6;
    localparam int COLOR_W    = 3;
    localparam int CFG_IDX_W  = 3;

    // fixed-point constants, Q16.16 and Q0.16
    localparam logic [LIFE_W-1:0]        ONE_Q16 = 17'h10000;
    localparam logic signed [33:0]       C_TENTH = 34'sd6554;
    localparam logic signed [WORD_W-1:0] C_PULL  = 32'sd19661;
    localparam logic signed [33:0]       C_RISE  = 34'sd52429;

    // life thresholds for the colour ramp, as exclusive upper bounds
    localparam logic [LIFE_W-1:0] LIFE_RED    = 17'd26215;
    localparam logic [LIFE_W-1:0] LIFE_ORANGE = 17'd39322;
    localparam logic [LIFE_W-1:0] LIFE_YELLOW = 17'd49152;
    localparam logic [LIFE_W-1:0] LIFE_BLUE   = 17'd55706;

    // exact reciprocal multiply: floor(a / d) = (a * m) >> 42 for a < 2^32
    localparam int               PROD_W         = 65;
    localparam int               DIV_SHIFT      = 42;
    localparam logic [32:0]      DIV750_MAGIC   = 33'd5864062015;
    localparam logic [32:0]      DIV1000_MAGIC  = 33'd4398046512;

    // random velocity terms
    localparam logic [RND_VEL_W-1:0] INIT_RND_MAX  = 6'd49;
    localparam logic signed [6:0]    INIT_RND_BIAS = 7'sd25;
    localparam logic signed [6:0]    SPAWN_RND_BIAS = 7'sd30;

    // fade rate lookup
    localparam int FADE_ENTRIES = 1 << RND_FADE_W;

    typedef logic [FADE_W-1:0] fade_t;
    typedef fade_t [FADE_ENTRIES-1:0] fade_lut_t;

    // item kinds
    typedef enum logic {
        KIND_INIT   = 1'b0,
        KIND_UPDATE = 1'b1
    } kind_t;

    // colour codes
    typedef enum logic [COLOR_W-1:0] {
        COLOR_WHITE  = 3'd0,
        COLOR_BLUE   = 3'd1,
        COLOR_YELLOW = 3'd2,
        COLOR_ORANGE = 3'd3,
        COLOR_RED    = 3'd4
    } color_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMIT_X    = 3'd0,
        CFG_EMIT_Y    = 3'd1,
        CFG_EMIT_Z    = 3'd2,
        CFG_PULL_X    = 3'd3,
        CFG_PULL_Y    = 3'd4,
        CFG_PULL_Z    = 3'd5,
        CFG_LAUNCH_VX = 3'd6,
        CFG_LAUNCH_VY = 3'd7
    } cfg_reg_t;

    // one particle entry as held in the table
    typedef struct packed {
        logic [LIFE_W-1:0]        life;
        fade_t                    fade;
        color_t                   color;
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] vel_z;
    } entry_t;

    localparam int PARTICLE_W = $bits(entry_t);

    // one input item as it travels down the pipeline
    typedef struct packed {
        kind_t                  kind;
        logic [INDEX_W-1:0]     index;
        logic                   in_range;
        logic [RND_FADE_W-1:0]  rnd_fade;
        logic [RND_VEL_W-1:0]   rnd_vel_x;
        logic [RND_VEL_W-1:0]   rnd_vel_y;
        logic [RND_VEL_W-1:0]   rnd_vel_z;
    } item_t;

    // fade = ((rnd + 3) * 65536 + 500) / 1000, built at elaboration
    function automatic fade_lut_t build_fade_lut();
        fade_lut_t lut;
        for (int i = 0; i < FADE_ENTRIES; i++) begin
            lut[i] = FADE_W'(((i + 3) * 65536 + 500) / 1000);
        end
        return lut;
    endfunction

    localparam fade_lut_t FADE_LUT = build_fade_lut();

    // sign extension to the wide sum format
    function automatic logic signed [33:0] sext34(input logic [WORD_W-1:0] v);
        return $signed({{2{v[WORD_W-1]}}, v});
    endfunction

    // clamp a wide sum to 32 bits signed
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [WORD_W-1:0] r;
        if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
            r = v[WORD_W-1:0];
        end
        else if (v[33]) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

    // quotient from the registered product, truncated toward zero
    function automatic logic signed [33:0] div_quot(input logic [PROD_W-1:0] prod,
                                                     input logic neg);
        logic signed [33:0] q;
        q = $signed(34'(prod >> DIV_SHIFT));
        return neg ? -q : q;
    endfunction

    // init velocity: (min(r, 49) - 25) * 10.0 in Q16.16
    function automatic logic signed [WORD_W-1:0] init_vel(input logic [RND_VEL_W-1:0] r);
        logic [RND_VEL_W-1:0] rc;
        logic signed [6:0]    d;
        logic signed [8:0]    d10;
        rc  = (r > INIT_RND_MAX) ? INIT_RND_MAX : r;
        d   = $signed({1'b0, rc}) - INIT_RND_BIAS;
        d10 = ({{2{d[6]}}, d} <<< 3) + ({{2{d[6]}}, d} <<< 1);
        return $signed({{7{d10[8]}}, d10, 16'd0});
    endfunction

    // respawn velocity offset: (r - 30) whole units in Q16.16
    function automatic logic signed [WORD_W-1:0] spawn_vel(input logic [RND_VEL_W-1:0] r);
        logic signed [6:0] d;
        d = $signed({1'b0, r}) - SPAWN_RND_BIAS;
        return $signed({{9{d[6]}}, d, 16'd0});
    endfunction

endpackage

// ===== rtl/fire_particle_update_core.sv =====
// Path: an accepted item moves through stage 1, stage 2 and stage 3; its result is offered from the output register.
// Throughput: one item per cycle while the output is not held; an item whose
// particle is still in flight waits until the earlier item on that entry
// leaves the last stage, set by read-modify-write through the single
// particle ram.
// Reset: configuration registers take their defaults and the pipeline empties;
// the particle table is not cleared.
module fire_particle_update_core #(
    parameter int PARTICLE_COUNT = 8192
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fpu_pkg::WORD_W-1:0]            cfg_data,
    // input items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [fpu_pkg::INDEX_W-1:0]           particle_index,
    input  logic [fpu_pkg::RND_FADE_W-1:0]        rnd_fade,
    input  logic [fpu_pkg::RND_VEL_W-1:0]         rnd_vel_x,
    input  logic [fpu_pkg::RND_VEL_W-1:0]         rnd_vel_y,
    input  logic [fpu_pkg::RND_VEL_W-1:0]         rnd_vel_z,
    // results
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [fpu_pkg::INDEX_W-1:0]           out_index,
    output logic signed [fpu_pkg::WORD_W-1:0]     pos_x_out,
    output logic signed [fpu_pkg::WORD_W-1:0]     pos_y_out,
    output logic signed [fpu_pkg::WORD_W-1:0]     pos_z_out,
    output logic [fpu_pkg::COLOR_W-1:0]           color_code,
    output logic [fpu_pkg::LIFE_W-1:0]            alpha
);

    import fpu_pkg::*;

    localparam int ADDR_W  = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
    localparam int COUNT_W = $clog2(PARTICLE_COUNT + 1) + 1;

    // configuration registers
    logic signed [WORD_W-1:0] emit_x_reg, emit_y_reg, emit_z_reg;
    logic signed [WORD_W-1:0] pull_x_reg, pull_y_reg, pull_z_reg;
    logic signed [WORD_W-1:0] launch_vx_reg, launch_vy_reg;

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_move, s2_move, s3_move;
    logic s1_free, s2_free, s3_free;
    logic hazard, in_accept;

    // pipeline payload
    item_t     in_item;
    item_t     s1_item_reg, s2_item_reg, s3_item_reg;
    entry_t    s1_state, s2_state_reg, s3_state_reg;
    logic [PROD_W-1:0] s1_prod_x, s1_prod_y, s1_prod_z;
    logic [PROD_W-1:0] s2_prod_x_reg, s2_prod_y_reg, s2_prod_z_reg;
    logic [WORD_W-1:0] s1_abs_x, s1_abs_y, s1_abs_z;
    logic s2_neg_x_reg, s2_neg_y_reg, s2_neg_z_reg;
    logic signed [WORD_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic signed [WORD_W-1:0] s3_pos_x_reg, s3_pos_y_reg, s3_pos_z_reg;
    logic signed [LIFE_W:0]   life_next, s3_life_reg;

    // write-back and result
    logic                     wr_en;
    entry_t                   wr_state;
    logic signed [WORD_W-1:0] pull;
    logic                     above_emit, respawn;
    color_t                   ramp_color;
    logic [PARTICLE_W-1:0]    ram_rdata;

    logic [INDEX_W-1:0]        res_index;
    logic signed [WORD_W-1:0]  res_pos_x, res_pos_y, res_pos_z;
    logic [COLOR_W-1:0]        res_color;
    logic [LIFE_W-1:0]         res_alpha;
    logic [INDEX_W-1:0]        out_index_reg;
    logic signed [WORD_W-1:0]  out_pos_x_reg, out_pos_y_reg, out_pos_z_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic [LIFE_W-1:0]         out_alpha_reg;

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_x_reg    <= '0;
            emit_y_reg    <= -32'sd327680;
            emit_z_reg    <= '0;
            pull_x_reg    <= '0;
            pull_y_reg    <= '0;
            pull_z_reg    <= '0;
            launch_vx_reg <= '0;
            launch_vy_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_EMIT_X:    emit_x_reg    <= cfg_data;
                CFG_EMIT_Y:    emit_y_reg    <= cfg_data;
                CFG_EMIT_Z:    emit_z_reg    <= cfg_data;
                CFG_PULL_X:    pull_x_reg    <= cfg_data;
                CFG_PULL_Y:    pull_y_reg    <= cfg_data;
                CFG_PULL_Z:    pull_z_reg    <= cfg_data;
                CFG_LAUNCH_VX: launch_vx_reg <= cfg_data;
                CFG_LAUNCH_VY: launch_vy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage advance, each stage fills as soon as it empties
    assign s3_move = s3_valid_reg && (!out_valid_reg || out_ready);
    assign s3_free = !s3_valid_reg || s3_move;
    assign s2_move = s2_valid_reg && s3_free;
    assign s2_free = !s2_valid_reg || s2_move;
    assign s1_move = s1_valid_reg && s2_free;
    assign s1_free = !s1_valid_reg || s1_move;

    // interlock: hold an item whose entry is still being modified
    assign hazard = (s1_valid_reg && (s1_item_reg.index == particle_index))
                 || (s2_valid_reg && (s2_item_reg.index == particle_index))
                 || (s3_valid_reg && (s3_item_reg.index == particle_index));

    assign in_ready  = s1_free && !hazard;
    assign in_accept = in_valid && in_ready;

    // incoming item
    always_comb
    begin
        in_item.kind      = kind_t'(kind);
        in_item.index     = particle_index;
        in_item.in_range  = (COUNT_W'(particle_index) < COUNT_W'(PARTICLE_COUNT));
        in_item.rnd_fade  = rnd_fade;
        in_item.rnd_vel_x = rnd_vel_x;
        in_item.rnd_vel_y = rnd_vel_y;
        in_item.rnd_vel_z = rnd_vel_z;
    end

    // particle table
    fpu_ram #(
        .WIDTH (PARTICLE_W),
        .DEPTH (PARTICLE_COUNT)
    ) u_particle_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ADDR_W'(s3_item_reg.index)),
        .wdata (wr_state),
        .re    (in_accept),
        .raddr (ADDR_W'(particle_index)),
        .rdata (ram_rdata)
    );

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_move;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_move;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s3_move;
            end
        end
    end

    // stage 1: table data arrives, start the velocity divides
    always_comb
    begin
        s1_state  = entry_t'(ram_rdata);
        s1_abs_x  = s1_state.vel_x[WORD_W-1] ? WORD_W'(-s1_state.vel_x) : s1_state.vel_x;
        s1_abs_y  = s1_state.vel_y[WORD_W-1] ? WORD_W'(-s1_state.vel_y) : s1_state.vel_y;
        s1_abs_z  = s1_state.vel_z[WORD_W-1] ? WORD_W'(-s1_state.vel_z) : s1_state.vel_z;
        s1_prod_x = PROD_W'(s1_abs_x) * PROD_W'(DIV750_MAGIC);
        s1_prod_y = PROD_W'(s1_abs_y) * PROD_W'(DIV1000_MAGIC);
        s1_prod_z = PROD_W'(s1_abs_z) * PROD_W'(DIV750_MAGIC);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_move)
        begin
            s2_item_reg   <= s1_item_reg;
            s2_state_reg  <= s1_state;
            s2_prod_x_reg <= s1_prod_x;
            s2_prod_y_reg <= s1_prod_y;
            s2_prod_z_reg <= s1_prod_z;
            s2_neg_x_reg  <= s1_state.vel_x[WORD_W-1];
            s2_neg_y_reg  <= s1_state.vel_y[WORD_W-1];
            s2_neg_z_reg  <= s1_state.vel_z[WORD_W-1];
        end
    end

    // stage 2: move the position, decay the life
    always_comb
    begin
        pos_x_next = sat32(sext34(s2_state_reg.pos_x) + div_quot(s2_prod_x_reg, s2_neg_x_reg));
        pos_y_next = sat32(sext34(s2_state_reg.pos_y) + div_quot(s2_prod_y_reg, s2_neg_y_reg));
        pos_z_next = sat32(sext34(s2_state_reg.pos_z) + div_quot(s2_prod_z_reg, s2_neg_z_reg));
        life_next  = $signed({1'b0, s2_state_reg.life})
                   - $signed({{(LIFE_W + 1 - FADE_W){1'b0}}, s2_state_reg.fade});
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_item_reg  <= s2_item_reg;
            s3_state_reg <= s2_state_reg;
            s3_pos_x_reg <= pos_x_next;
            s3_pos_y_reg <= pos_y_next;
            s3_pos_z_reg <= pos_z_next;
            s3_life_reg  <= life_next;
        end
    end

    // stage 3: pull toward the emitter
    always_comb
    begin
        above_emit = sext34(s3_pos_y_reg) > (sext34(emit_y_reg) + C_TENTH);
        pull       = '0;
        if (above_emit)
        begin
            if (s3_pos_x_reg > emit_x_reg)
            begin
                pull = -C_PULL;
            end
            else if (s3_pos_x_reg < emit_x_reg)
            begin
                pull = C_PULL;
            end
        end
    end

    // stage 3: colour ramp from the decayed life
    always_comb
    begin
        if (s3_life_reg[LIFE_W-1:0] < LIFE_RED)
        begin
            ramp_color = COLOR_RED;
        end
        else if (s3_life_reg[LIFE_W-1:0] < LIFE_ORANGE)
        begin
            ramp_color = COLOR_ORANGE;
        end
        else if (s3_life_reg[LIFE_W-1:0] < LIFE_YELLOW)
        begin
            ramp_color = COLOR_YELLOW;
        end
        else if (s3_life_reg[LIFE_W-1:0] < LIFE_BLUE)
        begin
            ramp_color = COLOR_BLUE;
        end
        else
        begin
            ramp_color = s3_state_reg.color;
        end
    end

    // stage 3: new entry for write-back
    assign respawn = s3_life_reg[LIFE_W];
    assign wr_en   = s3_move && s3_item_reg.in_range;

    always_comb
    begin
        if (s3_item_reg.kind == KIND_INIT)
        begin
            wr_state.life  = ONE_Q16;
            wr_state.fade  = FADE_LUT[s3_item_reg.rnd_fade];
            wr_state.color = COLOR_WHITE;
            wr_state.pos_x = '0;
            wr_state.pos_y = '0;
            wr_state.pos_z = '0;
            wr_state.vel_x = init_vel(s3_item_reg.rnd_vel_x);
            wr_state.vel_y = init_vel(s3_item_reg.rnd_vel_y);
            wr_state.vel_z = init_vel(s3_item_reg.rnd_vel_z);
        end
        else if (respawn)
        begin
            wr_state.life  = ONE_Q16;
            wr_state.fade  = FADE_LUT[s3_item_reg.rnd_fade];
            wr_state.color = COLOR_WHITE;
            wr_state.pos_x = emit_x_reg;
            wr_state.pos_y = emit_y_reg;
            wr_state.pos_z = emit_z_reg;
            wr_state.vel_x = sat32(sext34(launch_vx_reg)
                                   + sext34(spawn_vel(s3_item_reg.rnd_vel_x)));
            wr_state.vel_y = sat32(sext34(launch_vy_reg)
                                   + sext34(spawn_vel(s3_item_reg.rnd_vel_y)));
            wr_state.vel_z = spawn_vel(s3_item_reg.rnd_vel_z);
        end
        else
        begin
            wr_state.life  = s3_life_reg[LIFE_W-1:0];
            wr_state.fade  = s3_state_reg.fade;
            wr_state.color = ramp_color;
            wr_state.pos_x = s3_pos_x_reg;
            wr_state.pos_y = s3_pos_y_reg;
            wr_state.pos_z = s3_pos_z_reg;
            wr_state.vel_x = sat32(sext34(s3_state_reg.vel_x) + sext34(pull)
                                   + sext34(pull_x_reg));
            wr_state.vel_y = sat32(sext34(s3_state_reg.vel_y) + C_RISE
                                   + sext34(pull_y_reg));
            wr_state.vel_z = sat32(sext34(s3_state_reg.vel_z) + sext34(pull_z_reg));
        end
    end

    // stage 3: result fields, the entry as it stood before the step
    always_comb
    begin
        res_index = s3_item_reg.index;
        res_pos_x = '0;
        res_pos_y = '0;
        res_pos_z = '0;
        res_color = COLOR_WHITE;
        res_alpha = '0;
        if (s3_item_reg.in_range)
        begin
            if (s3_item_reg.kind == KIND_INIT)
            begin
                res_alpha = ONE_Q16;
            end
            else
            begin
                res_pos_x = s3_state_reg.pos_x;
                res_pos_y = s3_state_reg.pos_y;
                res_pos_z = s3_state_reg.pos_z;
                res_color = s3_state_reg.color;
                res_alpha = s3_state_reg.life;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            out_index_reg <= res_index;
            out_pos_x_reg <= res_pos_x;
            out_pos_y_reg <= res_pos_y;
            out_pos_z_reg <= res_pos_z;
            out_color_reg <= res_color;
            out_alpha_reg <= res_alpha;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign pos_x_out  = out_pos_x_reg;
    assign pos_y_out  = out_pos_y_reg;
    assign pos_z_out  = out_pos_z_reg;
    assign color_code = out_color_reg;
    assign alpha      = out_alpha_reg;

endmodule

// ===== rtl/fpu_ram.sv =====
// generic single-clock ram, one write port and one registered read port
module fpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, output holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/tb_fire_particle_update_core.sv =====
// self-checking testbench for fire_particle_update_core: directed and random particle traffic
module tb_fire_particle_update_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fpu_pkg::*;

    localparam int     TABLE_SIZE     = 8192;
    localparam int     UNIT           = 65536;
    localparam int     TENTH_Q16      = 6554;
    localparam int     PULL_Q16       = 19661;
    localparam int     RISE_Q16       = 52429;
    localparam int     INIT_VEL_CAP   = 49;
    localparam int     INIT_VEL_MID   = 25;
    localparam int     SPAWN_VEL_MID  = 30;
    localparam longint WORD_MAX       = 64'sd2147483647;
    localparam longint WORD_MIN       = -64'sd2147483648;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PHASE_ITEMS    = 75;

    typedef logic signed [WORD_W-1:0] q16_t;

    // one input transaction
    typedef struct packed {
        kind_t                 kind;
        logic [INDEX_W-1:0]    index;
        logic [RND_FADE_W-1:0] fade_rnd;
        logic [RND_VEL_W-1:0]  vx_rnd;
        logic [RND_VEL_W-1:0]  vy_rnd;
        logic [RND_VEL_W-1:0]  vz_rnd;
    } order_t;

    // one result transaction
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        q16_t               pos_x;
        q16_t               pos_y;
        q16_t               pos_z;
        color_t             colour;
        logic [LIFE_W-1:0]  alpha;
    } flare_t;

    typedef enum {SET_TAME, SET_TOP, SET_BOTTOM, SET_WILD, SET_ZERO} cfg_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0]     cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = 1'b0;
    logic [INDEX_W-1:0]    particle_index = '0;
    logic [RND_FADE_W-1:0] rnd_fade = '0;
    logic [RND_VEL_W-1:0]  rnd_vel_x = '0;
    logic [RND_VEL_W-1:0]  rnd_vel_y = '0;
    logic [RND_VEL_W-1:0]  rnd_vel_z = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [INDEX_W-1:0]    out_index;
    q16_t                  pos_x_out;
    q16_t                  pos_y_out;
    q16_t                  pos_z_out;
    logic [COLOR_W-1:0]    color_code;
    logic [LIFE_W-1:0]     alpha;

    // predicted particle table and register copy
    logic signed [LIFE_W:0] life_tab [TABLE_SIZE];
    logic [LIFE_W-1:0]      fade_tab [TABLE_SIZE];
    color_t                 colour_tab [TABLE_SIZE];
    q16_t                   pos_tab [TABLE_SIZE][3];
    q16_t                   vel_tab [TABLE_SIZE][3];
    q16_t                   emitter_cfg [8];

    order_t pending_orders[$];
    flare_t flares_due[$];
    order_t on_wire;
    bit     seeded [TABLE_SIZE];
    int     hot_slots[$];
    int     cold_slots[$];
    int     send_hold;
    int     send_burst;
    int     recv_hold;
    int     recv_burst;
    int     fault_count = 0;
    int     quiet_cycles = 0;

    fire_particle_update_core #(
        .PARTICLE_COUNT(TABLE_SIZE)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .particle_index (particle_index),
        .rnd_fade       (rnd_fade),
        .rnd_vel_x      (rnd_vel_x),
        .rnd_vel_y      (rnd_vel_y),
        .rnd_vel_z      (rnd_vel_z),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_index      (out_index),
        .pos_x_out      (pos_x_out),
        .pos_y_out      (pos_y_out),
        .pos_z_out      (pos_z_out),
        .color_code     (color_code),
        .alpha          (alpha)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // saturate a wide sum to a signed word
    function automatic q16_t clamp_word(longint v);
        if (v > WORD_MAX)
        begin
            return q16_t'(WORD_MAX);
        end
        if (v < WORD_MIN)
        begin
            return q16_t'(WORD_MIN);
        end
        return q16_t'(v);
    endfunction

    // fade per step from its random term, Q0.16
    function automatic logic [LIFE_W-1:0] fade_rate(logic [RND_FADE_W-1:0] r);
        return LIFE_W'(((int'(r) + 3) * UNIT + 500) / 1000);
    endfunction

    // report a particle and advance it one step in the predicted table
    function automatic flare_t step_particle(order_t o);
        flare_t                f;
        int                    slot;
        int                    lf;
        int                    pull;
        q16_t                  p [3];
        q16_t                  v [3];
        logic [RND_VEL_W-1:0]  rv [3];
        f = '0;
        f.index = o.index;
        slot = int'(o.index);
        rv[0] = o.vx_rnd;
        rv[1] = o.vy_rnd;
        rv[2] = o.vz_rnd;
        if (slot >= TABLE_SIZE)
        begin
            return f;
        end

        // initialise: full life, white, at the origin
        if (o.kind == KIND_INIT)
        begin
            life_tab[slot] = (LIFE_W + 1)'(UNIT);
            fade_tab[slot] = fade_rate(o.fade_rnd);
            colour_tab[slot] = COLOR_WHITE;
            for (int k = 0; k < 3; k++)
            begin
                pos_tab[slot][k] = '0;
                vel_tab[slot][k] = q16_t'(((int'(rv[k]) > INIT_VEL_CAP ? INIT_VEL_CAP
                                           : int'(rv[k])) - INIT_VEL_MID) * 10 * UNIT);
            end
            f.alpha = LIFE_W'(UNIT);
            return f;
        end

        // state before the step
        p = pos_tab[slot];
        v = vel_tab[slot];
        f.pos_x = p[0];
        f.pos_y = p[1];
        f.pos_z = p[2];
        f.colour = colour_tab[slot];
        f.alpha = LIFE_W'(life_tab[slot]);

        // move
        p[0] = clamp_word(longint'(p[0]) + longint'(v[0]) / 750);
        p[1] = clamp_word(longint'(p[1]) + longint'(v[1]) / 1000);
        p[2] = clamp_word(longint'(p[2]) + longint'(v[2]) / 750);

        // x pull toward the emitter once above it
        pull = 0;
        if (longint'(p[1]) > longint'(emitter_cfg[CFG_EMIT_Y]) + TENTH_Q16)
        begin
            if (p[0] > emitter_cfg[CFG_EMIT_X])
            begin
                pull = -PULL_Q16;
            end
            else if (p[0] < emitter_cfg[CFG_EMIT_X])
            begin
                pull = PULL_Q16;
            end
        end

        // accelerate
        v[0] = clamp_word(longint'(v[0]) + pull + longint'(emitter_cfg[CFG_PULL_X]));
        v[1] = clamp_word(longint'(v[1]) + RISE_Q16 + longint'(emitter_cfg[CFG_PULL_Y]));
        v[2] = clamp_word(longint'(v[2]) + longint'(emitter_cfg[CFG_PULL_Z]));

        // decay, then respawn or colour ramp
        lf = int'(life_tab[slot]) - int'(fade_tab[slot]);
        if (lf < 0)
        begin
            lf = UNIT;
            fade_tab[slot] = fade_rate(o.fade_rnd);
            p[0] = emitter_cfg[CFG_EMIT_X];
            p[1] = emitter_cfg[CFG_EMIT_Y];
            p[2] = emitter_cfg[CFG_EMIT_Z];
            v[0] = clamp_word(longint'(emitter_cfg[CFG_LAUNCH_VX])
                              + longint'(int'(rv[0]) - SPAWN_VEL_MID) * UNIT);
            v[1] = clamp_word(longint'(emitter_cfg[CFG_LAUNCH_VY])
                              + longint'(int'(rv[1]) - SPAWN_VEL_MID) * UNIT);
            v[2] = q16_t'((int'(rv[2]) - SPAWN_VEL_MID) * UNIT);
            colour_tab[slot] = COLOR_WHITE;
        end
        else if (longint'(lf) * 10 < 4 * UNIT)
        begin
            colour_tab[slot] = COLOR_RED;
        end
        else if (longint'(lf) * 10 < 6 * UNIT)
        begin
            colour_tab[slot] = COLOR_ORANGE;
        end
        else if (longint'(lf) * 4 < 3 * UNIT)
        begin
            colour_tab[slot] = COLOR_YELLOW;
        end
        else if (longint'(lf) * 20 < 17 * UNIT)
        begin
            colour_tab[slot] = COLOR_BLUE;
        end
        life_tab[slot] = (LIFE_W + 1)'(lf);
        pos_tab[slot] = p;
        vel_tab[slot] = v;
        return f;
    endfunction

    // idle length: mostly none, some short, a few long, with occasional busy runs
    function automatic int pick_gap(inout int burst);
        int roll;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // queue one input transaction and note which entries get initialised
    task automatic queue_order(kind_t k, int idx, int fr, int vx, int vy, int vz);
        order_t o;
        o.kind = k;
        o.index = INDEX_W'(idx);
        o.fade_rnd = RND_FADE_W'(fr);
        o.vx_rnd = RND_VEL_W'(vx);
        o.vy_rnd = RND_VEL_W'(vy);
        o.vz_rnd = RND_VEL_W'(vz);
        if (k == KIND_INIT)
        begin
            seeded[idx] = 1'b1;
        end
        pending_orders.push_back(o);
    endtask

    // random traffic, mostly updates on a small set of live particles
    task automatic queue_random(int n);
        int roll;
        int idx;
        int fr;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            fr = ($urandom_range(0, 9) < 7) ? $urandom_range(60, 127) : $urandom_range(0, 127);
            if (roll < 6)
            begin
                // fresh entry anywhere in the table
                idx = $urandom_range(0, TABLE_SIZE - 1);
                if (!seeded[idx])
                begin
                    cold_slots.push_back(idx);
                end
                queue_order(KIND_INIT, idx, fr, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 63));
            end
            else
            begin
                if (roll < 14 && cold_slots.size() != 0)
                begin
                    idx = cold_slots[$urandom_range(0, cold_slots.size() - 1)];
                end
                else
                begin
                    idx = hot_slots[$urandom_range(0, hot_slots.size() - 1)];
                end
                queue_order(kind_t'((roll < 22 || !seeded[idx]) ? KIND_INIT : KIND_UPDATE),
                            idx, fr, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 63));
            end
        end
    endtask

    // one register write transaction
    task automatic write_reg(cfg_reg_t r, q16_t d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        emitter_cfg[r] = d;
        cfg_valid <= 1'b0;
    endtask

    // program every register for one phase
    task automatic program_emitter(cfg_mode_t mode);
        cfg_reg_t r;
        q16_t     d;
        int       span;
        r = r.first();
        repeat (r.num())
        begin
            span = (r == CFG_PULL_X || r == CFG_PULL_Y || r == CFG_PULL_Z) ? UNIT / 2 : 8 * UNIT;
            case (mode)
                SET_TAME:   d = q16_t'(int'($urandom_range(0, 2 * span)) - span);
                SET_TOP:    d = q16_t'(WORD_MAX);
                SET_BOTTOM: d = q16_t'(WORD_MIN);
                SET_WILD:   d = q16_t'($urandom());
                default:    d = '0;
            endcase
            write_reg(r, d);
            r = r.next();
        end
    endtask

    // wait until nothing is queued, on the wire or outstanding
    task automatic settle();
        do
        begin
            @(negedge clk);
        end
        while (pending_orders.size() != 0 || in_valid || flares_due.size() != 0);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_hold = 0;
            send_burst = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                flares_due.push_back(step_particle(on_wire));
            end
            if (!in_valid || in_ready)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    in_valid <= 1'b0;
                end
                else if (pending_orders.size() != 0)
                begin
                    on_wire = pending_orders.pop_front();
                    kind <= on_wire.kind;
                    particle_index <= on_wire.index;
                    rnd_fade <= on_wire.fade_rnd;
                    rnd_vel_x <= on_wire.vx_rnd;
                    rnd_vel_y <= on_wire.vy_rnd;
                    rnd_vel_z <= on_wire.vz_rnd;
                    in_valid <= 1'b1;
                    send_hold = pick_gap(send_burst);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        flare_t got;
        flare_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold = 0;
            recv_burst = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got.index = out_index;
                got.pos_x = pos_x_out;
                got.pos_y = pos_y_out;
                got.pos_z = pos_z_out;
                got.colour = color_t'(color_code);
                got.alpha = alpha;
                if (flares_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("unexpected result transaction, index %0d", got.index);
                    end
                end
                else
                begin
                    want = flares_due.pop_front();
                    if (got !== want)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                        begin
                            $display("mismatch: index %0d/%0d pos %0d,%0d,%0d / %0d,%0d,%0d",
                                     want.index, got.index, want.pos_x, want.pos_y, want.pos_z,
                                     got.pos_x, got.pos_y, got.pos_z);
                            $display("          colour %0d/%0d alpha %0d/%0d (expected/actual)",
                                     want.colour, got.colour, want.alpha, got.alpha);
                        end
                    end
                end
                recv_hold = pick_gap(recv_burst);
            end
            else if (recv_hold == 0 && $urandom_range(0, 24) == 0)
            begin
                recv_hold = pick_gap(recv_burst);
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        cfg_mode_t plan [6];
        plan = '{SET_TAME, SET_TOP, SET_BOTTOM, SET_WILD, SET_ZERO, SET_TAME};

        // register defaults after reset
        foreach (emitter_cfg[i])
        begin
            emitter_cfg[i] = '0;
        end
        emitter_cfg[CFG_EMIT_Y] = -q16_t'(5 * UNIT);

        // small working set: table ends, middle, and a few at random
        hot_slots.push_back(0);
        hot_slots.push_back(TABLE_SIZE - 1);
        hot_slots.push_back(TABLE_SIZE / 2 - 1);
        repeat (9)
        begin
            hot_slots.push_back($urandom_range(0, TABLE_SIZE - 1));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: clamped and extreme random terms, fastest and slowest fade
        queue_order(KIND_INIT, 0, 127, 63, 63, 63);
        queue_order(KIND_INIT, TABLE_SIZE - 1, 0, 0, 0, 0);
        queue_order(KIND_INIT, TABLE_SIZE / 2 - 1, 40, 25, 49, 1);
        // x level with the emitter: no pull
        queue_order(KIND_UPDATE, TABLE_SIZE / 2 - 1, 0, 0, 0, 0);
        // fast fade runs through the colour ramp into a respawn
        for (int i = 0; i < 10; i++)
        begin
            queue_order(KIND_UPDATE, 0, (i % 2 == 0) ? 127 : 0, (i % 2 == 0) ? 63 : 0,
                        (i % 2 == 0) ? 0 : 63, 63);
        end
        // x below the emitter: positive pull
        queue_order(KIND_UPDATE, TABLE_SIZE - 1, 99, 0, 0, 0);
        queue_order(KIND_UPDATE, TABLE_SIZE - 1, 99, 0, 0, 0);
        queue_order(KIND_UPDATE, TABLE_SIZE / 2 - 1, 0, 0, 0, 0);
        // re-initialise a live entry, back to back with its update
        queue_order(KIND_INIT, 0, 99, 49, 49, 49);
        queue_order(KIND_UPDATE, 0, 99, 49, 49, 49);
        settle();

        // random phases, each under its own register setting
        foreach (plan[i])
        begin
            program_emitter(plan[i]);
            @(negedge clk);
            queue_random(PHASE_ITEMS);
            settle();
        end

        repeat (16) @(negedge clk);
        if (fault_count == 0 && flares_due.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
